// File: sv/sle_pkg.sv
// Shared types and constants for the sequential list engine.
package sle_pkg;

    localparam int CAPACITY = 1024;
    localparam int ADDR_W   = $clog2(CAPACITY);
    localparam int LEN_W    = 11;
    localparam int POS_W    = 11;
    localparam int VAL_W    = 32;

    typedef enum logic [1:0] {
        OP_INSERT = 2'd0,
        OP_CHANGE = 2'd1,
        OP_SEARCH = 2'd2,
        OP_DELETE = 2'd3
    } t_op;

    typedef enum logic [1:0] {
        ST_OK   = 2'd0,
        ST_CAP  = 2'd1,
        ST_POS  = 2'd2,
        ST_MISS = 2'd3
    } t_status;

    typedef enum logic [2:0] {
        S_IDLE,
        S_SRCH,
        S_SHIFT,
        S_PUT,
        S_DONE
    } t_state;

endpackage

// File: sv/sequential_list_engine.sv
// Ordered list of signed 32-bit values in one RAM: insert, change, search, delete.
// Search walks the list from the first entry and stops at a match; insert moves the entries
// from position p on up one place, last entry first, then writes the new value; delete moves
// the later entries down one place. Change, append and rejected requests skip the walk.
// One request in work at a time: the next input beat is taken no earlier than the result beat,
// and a stalled result holds the engine. Reset clears the length and handshake, not the RAM.
module sequential_list_engine
    import sle_pkg::*;
(
    input  logic                    i_clk,
    input  logic                    i_rst_n,
    input  logic                    i_in_valid,
    output logic                    o_in_ready,
    input  logic [1:0]              i_op,
    input  logic [POS_W-1:0]        i_position,
    input  logic signed [VAL_W-1:0] i_value,
    output logic                    o_out_valid,
    input  logic                    i_out_ready,
    output logic [1:0]              o_status,
    output logic [POS_W-1:0]        o_found_position,
    output logic [LEN_W-1:0]        o_list_length
);

    logic [VAL_W-1:0] r_mem [CAPACITY];
    logic [VAL_W-1:0] r_rdata;

    t_state              r_state, n_state;
    t_op                 r_op, n_op;
    logic [VAL_W-1:0]    r_val, n_val;
    logic [LEN_W-1:0]    r_len, n_len;
    logic [ADDR_W-1:0]   r_idx, n_idx;
    logic [LEN_W-1:0]    r_cnt, n_cnt;
    logic                r_pend, n_pend;
    logic [ADDR_W-1:0]   r_ptgt, n_ptgt;
    logic [ADDR_W-1:0]   r_put, n_put;
    logic                r_up, n_up;
    t_status             r_stat, n_stat;
    logic [POS_W-1:0]    r_found, n_found;

    logic                r_ovalid, n_ovalid;
    t_status             r_ostat, n_ostat;
    logic [POS_W-1:0]    r_ofound, n_ofound;
    logic [LEN_W-1:0]    r_olen, n_olen;

    logic                w_we;
    logic [ADDR_W-1:0]   w_waddr;
    logic [VAL_W-1:0]    w_wdata;
    logic [ADDR_W-1:0]   w_raddr;

    logic                w_acc;
    logic                w_out_free;
    t_op                 w_op;
    logic                w_pos_cap;
    logic                w_pos_zero;
    logic                w_pos_gt_len;
    logic                w_pos_gt_len1;
    logic                w_hit;

    assign w_acc         = i_in_valid && (r_state == S_IDLE);
    assign w_out_free    = !r_ovalid || i_out_ready;
    assign w_op          = t_op'(i_op);
    assign w_pos_cap     = {1'b0, i_position} > (POS_W+1)'(CAPACITY);
    assign w_pos_zero    = (i_position == '0);
    assign w_pos_gt_len  = {1'b0, i_position} > {1'b0, r_len};
    assign w_pos_gt_len1 = {1'b0, i_position} > ({1'b0, r_len} + (LEN_W+1)'(1));
    assign w_hit         = r_pend && (r_rdata == r_val);

    // Next state
    always_comb begin
        n_state = r_state;
        case (r_state)
            S_IDLE: begin
                if (w_acc) begin
                    if (w_op == OP_SEARCH) begin
                        n_state = (r_len == '0) ? S_DONE : S_SRCH;
                    end else if (w_pos_cap || w_pos_zero) begin
                        n_state = S_DONE;
                    end else if (w_op == OP_INSERT) begin
                        if (w_pos_gt_len1 || r_len >= LEN_W'(CAPACITY)) begin
                            n_state = S_DONE;
                        end else if ({1'b0, i_position} == {1'b0, r_len} + (LEN_W+1)'(1)) begin
                            n_state = S_PUT;
                        end else begin
                            n_state = S_SHIFT;
                        end
                    end else if (w_op == OP_DELETE) begin
                        if (w_pos_gt_len || i_position == r_len) begin
                            n_state = S_DONE;
                        end else begin
                            n_state = S_SHIFT;
                        end
                    end else begin
                        n_state = S_DONE;
                    end
                end
            end
            S_SRCH: begin
                if (w_hit || (r_cnt == '0 && !r_pend)) begin
                    n_state = S_DONE;
                end
            end
            S_SHIFT: begin
                if (r_cnt == '0 && !r_pend) begin
                    n_state = (r_op == OP_INSERT) ? S_PUT : S_DONE;
                end
            end
            S_PUT: begin
                n_state = S_DONE;
            end
            S_DONE: begin
                if (w_out_free) begin
                    n_state = S_IDLE;
                end
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

    // Datapath and RAM control
    always_comb begin
        n_op     = r_op;
        n_val    = r_val;
        n_len    = r_len;
        n_idx    = r_idx;
        n_cnt    = r_cnt;
        n_pend   = 1'b0;
        n_ptgt   = r_ptgt;
        n_put    = r_put;
        n_up     = r_up;
        n_stat   = r_stat;
        n_found  = r_found;
        n_ovalid = r_ovalid && !i_out_ready;
        n_ostat  = r_ostat;
        n_ofound = r_ofound;
        n_olen   = r_olen;
        w_we     = 1'b0;
        w_waddr  = r_ptgt;
        w_wdata  = r_rdata;
        w_raddr  = r_idx;
        case (r_state)
            S_IDLE: begin
                if (w_acc) begin
                    n_op    = w_op;
                    n_val   = i_value;
                    n_stat  = ST_OK;
                    n_found = '0;
                    n_put   = ADDR_W'(i_position - POS_W'(1));
                    if (w_op == OP_SEARCH) begin
                        n_stat = ST_MISS;
                        n_idx  = '0;
                        n_cnt  = r_len;
                    end else if (w_pos_cap) begin
                        n_stat = ST_CAP;
                    end else if (w_pos_zero) begin
                        n_stat = ST_POS;
                    end else if (w_op == OP_INSERT) begin
                        if (w_pos_gt_len1) begin
                            n_stat = ST_POS;
                        end else if (r_len >= LEN_W'(CAPACITY)) begin
                            n_stat = ST_CAP;
                        end else begin
                            // walk down from the last entry, each one moves up a place
                            n_up  = 1'b1;
                            n_idx = ADDR_W'(r_len - LEN_W'(1));
                            n_cnt = r_len - LEN_W'(i_position) + LEN_W'(1);
                        end
                    end else if (w_op == OP_CHANGE) begin
                        if (w_pos_gt_len) begin
                            n_stat = ST_POS;
                        end else begin
                            w_we    = 1'b1;
                            w_waddr = ADDR_W'(i_position - POS_W'(1));
                            w_wdata = i_value;
                        end
                    end else begin
                        if (w_pos_gt_len) begin
                            n_stat = ST_POS;
                        end else begin
                            // walk up from the entry after the hole, each one moves down
                            n_up  = 1'b0;
                            n_idx = ADDR_W'(i_position);
                            n_cnt = r_len - LEN_W'(i_position);
                            if (i_position == r_len) begin
                                n_len = r_len - LEN_W'(1);
                            end
                        end
                    end
                end
            end
            S_SRCH: begin
                if (w_hit) begin
                    n_stat  = ST_OK;
                    n_found = POS_W'(r_ptgt) + POS_W'(1);
                end else if (r_cnt != '0) begin
                    n_pend = 1'b1;
                    n_ptgt = r_idx;
                    n_idx  = r_idx + ADDR_W'(1);
                    n_cnt  = r_cnt - LEN_W'(1);
                end
            end
            S_SHIFT: begin
                // write back the entry read last cycle, one place over
                if (r_pend) begin
                    w_we = 1'b1;
                end
                if (r_cnt != '0) begin
                    n_pend = 1'b1;
                    n_cnt  = r_cnt - LEN_W'(1);
                    if (r_up) begin
                        n_ptgt = r_idx + ADDR_W'(1);
                        n_idx  = r_idx - ADDR_W'(1);
                    end else begin
                        n_ptgt = r_idx - ADDR_W'(1);
                        n_idx  = r_idx + ADDR_W'(1);
                    end
                end else if (!r_pend && r_op == OP_DELETE) begin
                    n_len = r_len - LEN_W'(1);
                end
            end
            S_PUT: begin
                w_we    = 1'b1;
                w_waddr = r_put;
                w_wdata = r_val;
                n_len   = r_len + LEN_W'(1);
            end
            S_DONE: begin
                if (w_out_free) begin
                    n_ovalid = 1'b1;
                    n_ostat  = r_stat;
                    n_ofound = r_found;
                    n_olen   = r_len;
                end
            end
            default: begin
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (w_we) begin
            r_mem[w_waddr] <= w_wdata;
        end
        r_rdata <= r_mem[w_raddr];
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state  <= S_IDLE;
            r_len    <= '0;
            r_pend   <= 1'b0;
            r_ovalid <= 1'b0;
        end else begin
            r_state  <= n_state;
            r_len    <= n_len;
            r_pend   <= n_pend;
            r_ovalid <= n_ovalid;
        end
    end

    always_ff @(posedge i_clk) begin
        r_op     <= n_op;
        r_val    <= n_val;
        r_idx    <= n_idx;
        r_cnt    <= n_cnt;
        r_ptgt   <= n_ptgt;
        r_put    <= n_put;
        r_up     <= n_up;
        r_stat   <= n_stat;
        r_found  <= n_found;
        r_ostat  <= n_ostat;
        r_ofound <= n_ofound;
        r_olen   <= n_olen;
    end

    assign o_in_ready       = (r_state == S_IDLE);
    assign o_out_valid      = r_ovalid;
    assign o_status         = r_ostat;
    assign o_found_position = r_ofound;
    assign o_list_length    = r_olen;

endmodule

// File: sv/sle_checker.sv
// Port-level checks for the sequential list engine, bound to the top level.
module sle_checker
    import sle_pkg::*;
(
    input logic                    i_clk,
    input logic                    i_rst_n,
    input logic                    i_in_valid,
    input logic                    o_in_ready,
    input logic                    o_out_valid,
    input logic                    i_out_ready,
    input logic [1:0]              o_status,
    input logic [POS_W-1:0]        o_found_position,
    input logic [LEN_W-1:0]        o_list_length
);

    a_out_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_out_valid && !i_out_ready) |=> (o_out_valid && $stable(o_status)
            && $stable(o_found_position) && $stable(o_list_length)))
        else $error("result beat dropped or changed while stalled");

    a_one_in_work: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_in_valid && o_in_ready) |=> !o_in_ready)
        else $error("input beat taken while a request is in work");

    a_found_ok: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_out_valid && o_found_position != '0) |-> (o_status == ST_OK))
        else $error("found position reported without ok status");

    a_len_cap: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid |-> ({1'b0, o_list_length} <= (LEN_W+1)'(CAPACITY)))
        else $error("list length beyond capacity");

endmodule

bind sequential_list_engine sle_checker u_sle_checker (.*);
